// File: src/rmj_pkg.sv
// shared constants and types for the radar measurement jacobian
`timescale 1ns / 1ps
`default_nettype none

package rmj_pkg;

	// fixed point format of every field
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int CFG_WIDTH = 16;

	// squared magnitudes, cross term and range cubed
	localparam int SUM_WIDTH = 2 * DATA_WIDTH;
	localparam int DEN_WIDTH = 3 * DATA_WIDTH;
	localparam int NUM_WIDTH = 3 * DATA_WIDTH + FRAC_BITS;

	// precheck stage, one stage per quotient bit, clip stage
	localparam int DIV_LATENCY = DATA_WIDTH + 2;

	localparam logic [CFG_WIDTH-1:0] MIN_RANGE_RESET = CFG_WIDTH'(7);

	typedef logic [DATA_WIDTH-1:0] word_t;

	// values that ride along the range square root
	typedef struct packed {
		word_t                px_mag;
		logic                 px_neg;
		word_t                py_mag;
		logic                 py_neg;
		logic [SUM_WIDTH-1:0] cr_mag;
		logic                 cr_neg;
	} side_t;

endpackage

`default_nettype wire

// File: src/rmj_sqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none

module rmj_sqrt (
	input  logic                           clk,
	input  logic                           en,
	input  logic [rmj_pkg::SUM_WIDTH-1:0]  rad,
	input  rmj_pkg::side_t                 side_in,
	output rmj_pkg::word_t                 root,
	output rmj_pkg::side_t                 side_out
);
	import rmj_pkg::*;

	localparam int TW = SUM_WIDTH + 1;

	logic [SUM_WIDTH-1:0] rem_q  [DATA_WIDTH];
	word_t                root_q [DATA_WIDTH];
	side_t                side_q [DATA_WIDTH];

	// stage k settles root bit DATA_WIDTH-1-k
	for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
		localparam int B = DATA_WIDTH - 1 - k;
		logic [SUM_WIDTH-1:0] rem_cur;
		word_t                root_cur;
		side_t                side_cur;
		logic [TW-1:0]        trial;
		logic [TW-1:0]        diff;
		logic                 fits;

		if (k == 0) begin : g_first
			assign rem_cur  = rad;
			assign root_cur = '0;
			assign side_cur = side_in;
		end else begin : g_next
			assign rem_cur  = rem_q[k-1];
			assign root_cur = root_q[k-1];
			assign side_cur = side_q[k-1];
		end

		// (root + 2^B)^2 - root^2
		assign trial = (TW'(root_cur) << (B + 1)) | (TW'(1) << (2 * B));
		assign fits  = {1'b0, rem_cur} >= trial;
		assign diff  = {1'b0, rem_cur} - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= fits ? diff[SUM_WIDTH-1:0] : rem_cur;
				root_q[k] <= fits ? (root_cur | (word_t'(1) << B)) : root_cur;
				side_q[k] <= side_cur;
			end
		end
	end

	assign root     = root_q[DATA_WIDTH-1];
	assign side_out = side_q[DATA_WIDTH-1];

endmodule

`default_nettype wire

// File: src/rmj_div.sv
// pipelined restoring divider with truncation and signed clipping
`timescale 1ns / 1ps
`default_nettype none

module rmj_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rmj_pkg::NUM_WIDTH-1:0] num,
	input  logic [rmj_pkg::DEN_WIDTH-1:0] den,
	input  logic                          neg,
	output rmj_pkg::word_t                res,
	output logic                          clip
);
	import rmj_pkg::*;

	localparam int TW = DEN_WIDTH + 1;

	logic [DEN_WIDTH-1:0] rem0_q;
	logic [DEN_WIDTH-1:0] den0_q;
	word_t                low0_q;
	logic                 neg0_q;
	logic                 ovf0_q;

	logic [DEN_WIDTH-1:0] rem_q [DATA_WIDTH];
	logic [DEN_WIDTH-1:0] den_q [DATA_WIDTH];
	word_t                low_q [DATA_WIDTH];
	word_t                quo_q [DATA_WIDTH];
	logic                 neg_q [DATA_WIDTH];
	logic                 ovf_q [DATA_WIDTH];

	word_t res_q;
	logic  clip_q;
	word_t lim;
	word_t quo_fin;
	word_t mag;
	logic  over;

	// quotient needs more than DATA_WIDTH bits when the high part reaches the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			rem0_q <= DEN_WIDTH'(num[NUM_WIDTH-1:DATA_WIDTH]);
			low0_q <= num[DATA_WIDTH-1:0];
			den0_q <= den;
			neg0_q <= neg;
			ovf0_q <= DEN_WIDTH'(num[NUM_WIDTH-1:DATA_WIDTH]) >= den;
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
		logic [DEN_WIDTH-1:0] rem_cur;
		logic [DEN_WIDTH-1:0] den_cur;
		word_t                low_cur;
		word_t                quo_cur;
		logic                 neg_cur;
		logic                 ovf_cur;
		logic [TW-1:0]        part;
		logic [TW-1:0]        diff;
		logic                 ge;

		if (k == 0) begin : g_first
			assign rem_cur = rem0_q;
			assign den_cur = den0_q;
			assign low_cur = low0_q;
			assign quo_cur = '0;
			assign neg_cur = neg0_q;
			assign ovf_cur = ovf0_q;
		end else begin : g_next
			assign rem_cur = rem_q[k-1];
			assign den_cur = den_q[k-1];
			assign low_cur = low_q[k-1];
			assign quo_cur = quo_q[k-1];
			assign neg_cur = neg_q[k-1];
			assign ovf_cur = ovf_q[k-1];
		end

		assign part = {rem_cur, low_cur[DATA_WIDTH-1]};
		assign ge   = part >= {1'b0, den_cur};
		assign diff = part - {1'b0, den_cur};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? diff[DEN_WIDTH-1:0] : part[DEN_WIDTH-1:0];
				den_q[k] <= den_cur;
				low_q[k] <= low_cur << 1;
				quo_q[k] <= {quo_cur[DATA_WIDTH-2:0], ge};
				neg_q[k] <= neg_cur;
				ovf_q[k] <= ovf_cur;
			end
		end
	end

	// clip to the signed range, then apply the sign
	always_comb begin
		quo_fin = quo_q[DATA_WIDTH-1];
		lim     = neg_q[DATA_WIDTH-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
		                              : {1'b0, {(DATA_WIDTH-1){1'b1}}};
		over    = ovf_q[DATA_WIDTH-1] || (quo_fin > lim);
		mag     = over ? lim : quo_fin;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q  <= neg_q[DATA_WIDTH-1] ? (~mag + word_t'(1)) : mag;
			clip_q <= over;
		end
	end

	assign res  = res_q;
	assign clip = clip_q;

endmodule

`default_nettype wire

// File: src/radar_measurement_jacobian.sv
// top level of the radar measurement jacobian pipeline
`timescale 1ns / 1ps
`default_nettype none

// Radar measurement Jacobian: takes a tracked state (pos_x, pos_y, vel_x,
// vel_y, signed Q15.16) and returns the six distinct entries of the polar
// measurement Jacobian, with the range d = floor(sqrt(px^2 + py^2)) raised to
// min_range (0 acts as 1) before any division. Quotients truncate toward zero
// and clip to the signed 32-bit range; saturated flags any clip or a raised
// range. The block takes one transaction per cycle unless in_stall is high. Each
// transaction passes through the magnitude, product and cross-term stages, 32
// square root stages (one root bit each), the clamp and range power stages,
// the dividers (a precheck, one quotient bit per stage and a clip stage), and
// the output register. A result waiting in the output register does not block
// new input while the last pipeline stage is empty.
// min_range is written over the cfg port, which is always ready.
module radar_measurement_jacobian (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [rmj_pkg::DATA_WIDTH-1:0] pos_x,
	input  logic signed [rmj_pkg::DATA_WIDTH-1:0] pos_y,
	input  logic signed [rmj_pkg::DATA_WIDTH-1:0] vel_x,
	input  logic signed [rmj_pkg::DATA_WIDTH-1:0] vel_y,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [rmj_pkg::DATA_WIDTH-1:0] dr_dpx,
	output logic signed [rmj_pkg::DATA_WIDTH-1:0] dr_dpy,
	output logic signed [rmj_pkg::DATA_WIDTH-1:0] dphi_dpx,
	output logic signed [rmj_pkg::DATA_WIDTH-1:0] dphi_dpy,
	output logic signed [rmj_pkg::DATA_WIDTH-1:0] drate_dpx,
	output logic signed [rmj_pkg::DATA_WIDTH-1:0] drate_dpy,
	output logic                                  saturated,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rmj_pkg::CFG_WIDTH-1:0]         cfg_data
);
	import rmj_pkg::*;

	localparam int N_ENT = 6;

	function automatic word_t mag_of(input word_t x);
		return x[DATA_WIDTH-1] ? (~x + word_t'(1)) : x;
	endfunction

	logic [CFG_WIDTH-1:0] min_range_q;
	logic                 en;
	logic                 load;
	logic                 last_v;

	// stage 1: magnitudes and signs
	logic  v_s1;
	word_t px_mag_s1, py_mag_s1, vx_mag_s1, vy_mag_s1;
	logic  px_neg_s1, py_neg_s1, vx_neg_s1, vy_neg_s1;

	// stage 2: products
	logic                 v_s2;
	logic [SUM_WIDTH-1:0] pxx_s2, pyy_s2, t1_s2, t2_s2;
	logic                 n1_s2, n2_s2;
	word_t                px_mag_s2, py_mag_s2;
	logic                 px_neg_s2, py_neg_s2;

	// stage 3: sum of squares and cross term
	logic                 v_s3;
	logic [SUM_WIDTH-1:0] sum_s3;
	side_t                side_s3;
	logic [SUM_WIDTH-1:0] cr_mag;
	logic                 cr_neg;

	// square root
	logic [DATA_WIDTH-1:0] sq_v_q;
	word_t                 sq_root;
	side_t                 sq_side;

	// stage 4: range clamp
	logic  v_s4;
	word_t d1_s4;
	logic  sat_s4;
	side_t side_s4;
	word_t dmin;

	// stage 5: range squared, cross products partials, signs
	logic                 v_s5;
	logic [SUM_WIDTH-1:0] d2_s5, pyl_s5, pyh_s5, pxl_s5, pxh_s5;
	word_t                d1_s5, px_mag_s5, py_mag_s5;
	logic [N_ENT-1:0]     neg_s5;
	logic                 sat_s5;

	// stage 6: range cubed partials, rate numerators
	logic                 v_s6;
	logic [SUM_WIDTH-1:0] d3a_s6, d3b_s6, d2_s6;
	logic [DEN_WIDTH-1:0] ny_s6, nx_s6;
	word_t                d1_s6, px_mag_s6, py_mag_s6;
	logic [N_ENT-1:0]     neg_s6;
	logic                 sat_s6;

	// stage 7: range cubed
	logic                 v_s7;
	logic [DEN_WIDTH-1:0] d3_s7, ny_s7, nx_s7;
	logic [SUM_WIDTH-1:0] d2_s7;
	word_t                d1_s7, px_mag_s7, py_mag_s7;
	logic [N_ENT-1:0]     neg_s7;
	logic                 sat_s7;

	// dividers
	logic [NUM_WIDTH-1:0]   dv_num [N_ENT];
	logic [DEN_WIDTH-1:0]   dv_den [N_ENT];
	word_t                  dv_res [N_ENT];
	logic [N_ENT-1:0]       dv_clip;
	logic [DIV_LATENCY-1:0] dv_v_q;
	logic [DIV_LATENCY-1:0] dv_sat_q;

	// output register
	logic  out_valid_q;
	word_t res_q [N_ENT];
	logic  sat_q;

	// pipeline moves unless the last stage holds a result the output cannot take
	assign load     = !out_valid_q || !out_stall;
	assign last_v   = dv_v_q[DIV_LATENCY-1];
	assign en       = load || !last_v;
	assign in_stall = !en;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q <= MIN_RANGE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			min_range_q <= cfg_data;
		end
	end

	// valid bits through every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			sq_v_q      <= '0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			dv_v_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (en) begin
				v_s1   <= in_valid;
				v_s2   <= v_s1;
				v_s3   <= v_s2;
				sq_v_q <= {sq_v_q[DATA_WIDTH-2:0], v_s3};
				v_s4   <= sq_v_q[DATA_WIDTH-1];
				v_s5   <= v_s4;
				v_s6   <= v_s5;
				v_s7   <= v_s6;
				dv_v_q <= {dv_v_q[DIV_LATENCY-2:0], v_s7};
			end
			if (load) begin
				out_valid_q <= last_v;
			end
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (en) begin
			px_mag_s1 <= mag_of(word_t'(pos_x));
			py_mag_s1 <= mag_of(word_t'(pos_y));
			vx_mag_s1 <= mag_of(word_t'(vel_x));
			vy_mag_s1 <= mag_of(word_t'(vel_y));
			px_neg_s1 <= pos_x[DATA_WIDTH-1];
			py_neg_s1 <= pos_y[DATA_WIDTH-1];
			vx_neg_s1 <= vel_x[DATA_WIDTH-1];
			vy_neg_s1 <= vel_y[DATA_WIDTH-1];
		end
	end

	// stage 2
	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s2    <= SUM_WIDTH'(px_mag_s1) * SUM_WIDTH'(px_mag_s1);
			pyy_s2    <= SUM_WIDTH'(py_mag_s1) * SUM_WIDTH'(py_mag_s1);
			t1_s2     <= SUM_WIDTH'(vx_mag_s1) * SUM_WIDTH'(py_mag_s1);
			t2_s2     <= SUM_WIDTH'(vy_mag_s1) * SUM_WIDTH'(px_mag_s1);
			n1_s2     <= vx_neg_s1 != py_neg_s1;
			n2_s2     <= vy_neg_s1 != px_neg_s1;
			px_mag_s2 <= px_mag_s1;
			py_mag_s2 <= py_mag_s1;
			px_neg_s2 <= px_neg_s1;
			py_neg_s2 <= py_neg_s1;
		end
	end

	// cross term vx*py - vy*px as magnitude and sign
	always_comb begin
		if (n1_s2 != n2_s2) begin
			cr_mag = t1_s2 + t2_s2;
			cr_neg = n1_s2;
		end else if (t1_s2 >= t2_s2) begin
			cr_mag = t1_s2 - t2_s2;
			cr_neg = n1_s2;
		end else begin
			cr_mag = t2_s2 - t1_s2;
			cr_neg = !n1_s2;
		end
	end

	// stage 3
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3         <= pxx_s2 + pyy_s2;
			side_s3.px_mag <= px_mag_s2;
			side_s3.px_neg <= px_neg_s2;
			side_s3.py_mag <= py_mag_s2;
			side_s3.py_neg <= py_neg_s2;
			side_s3.cr_mag <= cr_mag;
			side_s3.cr_neg <= cr_neg;
		end
	end

	rmj_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.rad      (sum_s3),
		.side_in  (side_s3),
		.root     (sq_root),
		.side_out (sq_side)
	);

	// stage 4: raise the range to its minimum
	assign dmin = (min_range_q == '0) ? word_t'(1) : word_t'(min_range_q);

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s4   <= (sq_root < dmin) ? dmin : sq_root;
			sat_s4  <= sq_root < dmin;
			side_s4 <= sq_side;
		end
	end

	// stage 5
	always_ff @(posedge clk) begin
		if (en) begin
			d2_s5     <= SUM_WIDTH'(d1_s4) * SUM_WIDTH'(d1_s4);
			pyl_s5    <= SUM_WIDTH'(side_s4.py_mag) *
			             SUM_WIDTH'(side_s4.cr_mag[DATA_WIDTH-1:0]);
			pyh_s5    <= SUM_WIDTH'(side_s4.py_mag) *
			             SUM_WIDTH'(side_s4.cr_mag[SUM_WIDTH-1:DATA_WIDTH]);
			pxl_s5    <= SUM_WIDTH'(side_s4.px_mag) *
			             SUM_WIDTH'(side_s4.cr_mag[DATA_WIDTH-1:0]);
			pxh_s5    <= SUM_WIDTH'(side_s4.px_mag) *
			             SUM_WIDTH'(side_s4.cr_mag[SUM_WIDTH-1:DATA_WIDTH]);
			d1_s5     <= d1_s4;
			px_mag_s5 <= side_s4.px_mag;
			py_mag_s5 <= side_s4.py_mag;
			neg_s5[0] <= side_s4.px_neg;
			neg_s5[1] <= side_s4.py_neg;
			neg_s5[2] <= !side_s4.py_neg && (side_s4.py_mag != '0);
			neg_s5[3] <= side_s4.px_neg;
			neg_s5[4] <= side_s4.py_neg != side_s4.cr_neg;
			neg_s5[5] <= side_s4.px_neg == side_s4.cr_neg;
			sat_s5    <= sat_s4;
		end
	end

	// stage 6
	always_ff @(posedge clk) begin
		if (en) begin
			d3a_s6    <= SUM_WIDTH'(d2_s5[DATA_WIDTH-1:0]) * SUM_WIDTH'(d1_s5);
			d3b_s6    <= SUM_WIDTH'(d2_s5[SUM_WIDTH-1:DATA_WIDTH]) * SUM_WIDTH'(d1_s5);
			ny_s6     <= DEN_WIDTH'(pyl_s5) + (DEN_WIDTH'(pyh_s5) << DATA_WIDTH);
			nx_s6     <= DEN_WIDTH'(pxl_s5) + (DEN_WIDTH'(pxh_s5) << DATA_WIDTH);
			d2_s6     <= d2_s5;
			d1_s6     <= d1_s5;
			px_mag_s6 <= px_mag_s5;
			py_mag_s6 <= py_mag_s5;
			neg_s6    <= neg_s5;
			sat_s6    <= sat_s5;
		end
	end

	// stage 7
	always_ff @(posedge clk) begin
		if (en) begin
			d3_s7     <= DEN_WIDTH'(d3a_s6) + (DEN_WIDTH'(d3b_s6) << DATA_WIDTH);
			ny_s7     <= ny_s6;
			nx_s7     <= nx_s6;
			d2_s7     <= d2_s6;
			d1_s7     <= d1_s6;
			px_mag_s7 <= px_mag_s6;
			py_mag_s7 <= py_mag_s6;
			neg_s7    <= neg_s6;
			sat_s7    <= sat_s6;
		end
	end

	// numerators and divisors of the six entries
	always_comb begin
		dv_num[0] = NUM_WIDTH'(px_mag_s7) << FRAC_BITS;
		dv_num[1] = NUM_WIDTH'(py_mag_s7) << FRAC_BITS;
		dv_num[2] = NUM_WIDTH'(py_mag_s7) << (2 * FRAC_BITS);
		dv_num[3] = NUM_WIDTH'(px_mag_s7) << (2 * FRAC_BITS);
		dv_num[4] = NUM_WIDTH'(ny_s7) << FRAC_BITS;
		dv_num[5] = NUM_WIDTH'(nx_s7) << FRAC_BITS;
		dv_den[0] = DEN_WIDTH'(d1_s7);
		dv_den[1] = DEN_WIDTH'(d1_s7);
		dv_den[2] = DEN_WIDTH'(d2_s7);
		dv_den[3] = DEN_WIDTH'(d2_s7);
		dv_den[4] = d3_s7;
		dv_den[5] = d3_s7;
	end

	for (genvar e = 0; e < N_ENT; e++) begin : g_div
		rmj_div u_div (
			.clk  (clk),
			.en   (en),
			.num  (dv_num[e]),
			.den  (dv_den[e]),
			.neg  (neg_s7[e]),
			.res  (dv_res[e]),
			.clip (dv_clip[e])
		);
	end

	// clamp flag alongside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			dv_sat_q <= {dv_sat_q[DIV_LATENCY-2:0], sat_s7};
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load && last_v) begin
			for (int i = 0; i < N_ENT; i++) begin
				res_q[i] <= dv_res[i];
			end
			sat_q <= dv_sat_q[DIV_LATENCY-1] || (dv_clip != '0);
		end
	end

	assign out_valid = out_valid_q;
	assign dr_dpx    = $signed(res_q[0]);
	assign dr_dpy    = $signed(res_q[1]);
	assign dphi_dpx  = $signed(res_q[2]);
	assign dphi_dpy  = $signed(res_q[3]);
	assign drate_dpx = $signed(res_q[4]);
	assign drate_dpy = $signed(res_q[5]);
	assign saturated = sat_q;

endmodule

`default_nettype wire

// File: src/rmj_checker.sv
// port level checks for the radar measurement jacobian and their binding
`timescale 1ns / 1ps
`default_nettype none

module rmj_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_stall,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [rmj_pkg::DATA_WIDTH-1:0] dr_dpx,
	input  logic signed [rmj_pkg::DATA_WIDTH-1:0] dr_dpy,
	input  logic signed [rmj_pkg::DATA_WIDTH-1:0] dphi_dpx,
	input  logic signed [rmj_pkg::DATA_WIDTH-1:0] dphi_dpy,
	input  logic signed [rmj_pkg::DATA_WIDTH-1:0] drate_dpx,
	input  logic signed [rmj_pkg::DATA_WIDTH-1:0] drate_dpy,
	input  logic                                  saturated
);

	// a stalled result transaction stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result transaction keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(dr_dpx) && $stable(dr_dpy) &&
			$stable(dphi_dpx) && $stable(dphi_dpy) && $stable(drate_dpx) &&
			$stable(drate_dpy) && $stable(saturated))
		else $error("result payload changed while stalled");

	// input backs up only behind a waiting, stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// no result comes out of reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result offered right after reset");

endmodule

bind radar_measurement_jacobian rmj_checker u_rmj_checker (.*);

`default_nettype wire
